### hdl/slot_memory_map_decoder_macros.svh
// Assertion macros for the slot memory map decoder.
// Used by the RTL module that carries concurrent checks; needs clk and rst_n in scope.
`ifndef SLOT_MEMORY_MAP_DECODER_MACROS_SVH
`define SLOT_MEMORY_MAP_DECODER_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define SMMD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define SMMD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/smmd_pkg.sv
// Shared constants, codes and types of the slot memory map decoder.
// No dependencies; the interfaces, check unit, mapping store and top level use it by scoped names.
package smmd_pkg;

  // Address space and slot geometry.
  localparam int ADDR_BITS     = 20;
  localparam int SLOT_BYTES    = 4096;
  localparam int BLOCK_ID_BITS = 6;
  localparam int SLOT_BITS     = $clog2(SLOT_BYTES);
  localparam int SLOT_IDX_BITS = ADDR_BITS - SLOT_BITS;
  localparam int SLOT_COUNT    = 1 << SLOT_IDX_BITS;
  localparam int CNT_BITS      = SLOT_IDX_BITS + 1;
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

  // Item field widths.
  localparam int OP_W     = 3;
  localparam int ID_W     = BLOCK_ID_BITS;
  localparam int WORD_W   = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_RESTORE   = 3'd1,
    OP_FREE      = 3'd2,
    OP_WINDOW    = 3'd3,
    OP_RD_LOOKUP = 3'd4,
    OP_WR_LOOKUP = 3'd5
  } op_t;

  // Access modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_RD = 2'd0,
    MODE_WR = 2'd1,
    MODE_RW = 2'd2
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_LEN      = 3'd1,
    ST_SRC_SIZE = 3'd2,
    ST_RANGE    = 3'd3,
    ST_MODE     = 3'd4,
    ST_BAD_ARG  = 3'd5
  } status_t;

  // One input item as held inside the block.
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   block_id;
    logic [WORD_W-1:0] block_size;
    logic              use_block_size;
    logic [WORD_W-1:0] source_offset;
    logic [WORD_W-1:0] address;
    logic [WORD_W-1:0] source_address;
    logic [WORD_W-1:0] length;
    logic [MODE_W-1:0] access_mode;
  } item_t;

  // One result item.
  typedef struct packed {
    status_t              status;
    logic                 hit;
    logic [ID_W-1:0]      found_block;
    logic [ADDR_BITS-1:0] block_offset;
  } result_t;

  // One mapping: block id (0 = unmapped) and base address.
  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [ADDR_BITS-1:0] base;
  } entry_t;

  // Outcome of the argument checks and the slot run to walk.
  typedef struct packed {
    status_t                  status;
    logic [CNT_BITS-1:0]      n_slots;
    logic [SLOT_IDX_BITS-1:0] dst_first;
    logic [SLOT_IDX_BITS-1:0] src_first;
    logic [ADDR_BITS-1:0]     base;
  } plan_t;

  // Sequencer command to the mapping store.
  typedef struct packed {
    logic [SLOT_IDX_BITS-1:0] raddr;
    logic [SLOT_IDX_BITS-1:0] waddr;
    logic                     rd_we;
    logic                     wr_we;
    entry_t                   rd_wdata;
    entry_t                   wr_wdata;
  } store_cmd_t;

endpackage

### hdl/smmd_in_if.sv
// Input channel of the slot memory map decoder: valid/ready plus one item.
// Depends on smmd_pkg for field widths.
interface smmd_in_if;
  logic                                valid;
  logic                                ready;
  logic [smmd_pkg::OP_W-1:0]           operation;
  logic [smmd_pkg::ID_W-1:0]           block_id;
  logic [smmd_pkg::WORD_W-1:0]         block_size;
  logic                                use_block_size;
  logic [smmd_pkg::WORD_W-1:0]         source_offset;
  logic [smmd_pkg::WORD_W-1:0]         address;
  logic [smmd_pkg::WORD_W-1:0]         source_address;
  logic [smmd_pkg::WORD_W-1:0]         length;
  logic [smmd_pkg::MODE_W-1:0]         access_mode;

  modport source (
    output valid, operation, block_id, block_size, use_block_size, source_offset,
           address, source_address, length, access_mode,
    input  ready
  );

  modport sink (
    input  valid, operation, block_id, block_size, use_block_size, source_offset,
           address, source_address, length, access_mode,
    output ready
  );
endinterface

### hdl/smmd_out_if.sv
// Result channel of the slot memory map decoder: valid/ready plus one item.
// Depends on smmd_pkg for field widths.
interface smmd_out_if;
  logic                             valid;
  logic                             ready;
  logic [smmd_pkg::STATUS_W-1:0]    status;
  logic                             hit;
  logic [smmd_pkg::ID_W-1:0]        found_block;
  logic [smmd_pkg::ADDR_BITS-1:0]   block_offset;

  modport source (
    output valid, status, hit, found_block, block_offset,
    input  ready
  );

  modport sink (
    input  valid, status, hit, found_block, block_offset,
    output ready
  );
endinterface

### hdl/smmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; a read sees the old data on a collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/smmd_check.sv
// Argument check unit: validates a held item and works out the slot run.
// Depends on smmd_pkg.
module smmd_check (
  input  smmd_pkg::item_t item,
  output smmd_pkg::plan_t plan
);

  // True when start and start + len - 1 both lie in the address space.
  function automatic logic range_ok(input logic [31:0] start, input logic [31:0] len);
    logic [31:0] last;
    logic [32:0] end_x;
    last  = start + len - 32'd1;
    end_x = {1'b0, start} + {1'b0, len};
    return !((start > smmd_pkg::ADDR_MASK) || (last > smmd_pkg::ADDR_MASK) ||
             ((len != 32'd0) && (end_x > 33'h1_0000_0000)));
  endfunction

  logic [31:0] eff_len;
  logic [31:0] src_end;
  logic        len_bad;
  logic        src_misal;
  logic        dst_misal;
  logic        dst_rng_ok;
  logic        src_rng_ok;

  // Shared compare logic for all checks.
  always_comb begin
    eff_len = ((item.operation == smmd_pkg::OP_ALLOC) && item.use_block_size) ?
              item.block_size : item.length;
    src_end    = item.source_offset + eff_len;
    len_bad    = (eff_len[smmd_pkg::SLOT_BITS-1:0] != '0);
    src_misal  = (item.source_address[smmd_pkg::SLOT_BITS-1:0] != '0);
    dst_misal  = (item.address[smmd_pkg::SLOT_BITS-1:0] != '0);
    dst_rng_ok = range_ok(item.address, eff_len);
    src_rng_ok = range_ok(item.source_address, eff_len);
  end

  // Status in the priority order of each operation, plus the run to walk.
  always_comb begin
    plan.status    = smmd_pkg::ST_OK;
    plan.n_slots   = smmd_pkg::CNT_BITS'(eff_len >> smmd_pkg::SLOT_BITS);
    plan.dst_first = item.address[smmd_pkg::ADDR_BITS-1:smmd_pkg::SLOT_BITS];
    plan.src_first = item.address[smmd_pkg::ADDR_BITS-1:smmd_pkg::SLOT_BITS];
    plan.base      = smmd_pkg::ADDR_BITS'(item.address - item.source_offset);
    case (item.operation)
      smmd_pkg::OP_ALLOC: begin
        if (item.block_id == '0) begin
          plan.status = smmd_pkg::ST_BAD_ARG;
        end else if (len_bad) begin
          plan.status = smmd_pkg::ST_LEN;
        end else if (src_end > item.block_size) begin
          plan.status = smmd_pkg::ST_SRC_SIZE;
        end else if (!dst_rng_ok) begin
          plan.status = smmd_pkg::ST_RANGE;
        end else if (!((item.access_mode == smmd_pkg::MODE_RD) ||
                       (item.access_mode == smmd_pkg::MODE_WR) ||
                       (item.access_mode == smmd_pkg::MODE_RW))) begin
          plan.status = smmd_pkg::ST_MODE;
        end
      end
      smmd_pkg::OP_RESTORE: begin
        if (!((item.access_mode == smmd_pkg::MODE_RD) ||
              (item.access_mode == smmd_pkg::MODE_WR))) begin
          plan.status = smmd_pkg::ST_MODE;
        end else if (len_bad) begin
          plan.status = smmd_pkg::ST_LEN;
        end else if (!dst_rng_ok) begin
          plan.status = smmd_pkg::ST_RANGE;
        end
      end
      smmd_pkg::OP_FREE: begin
        // Free walks every slot from the bottom.
        plan.n_slots   = smmd_pkg::CNT_BITS'(smmd_pkg::SLOT_COUNT);
        plan.dst_first = '0;
        plan.src_first = '0;
        if (item.block_id == '0) begin
          plan.status = smmd_pkg::ST_BAD_ARG;
        end
      end
      smmd_pkg::OP_WINDOW: begin
        // The base field carries the shift from source to window.
        plan.src_first =
          item.source_address[smmd_pkg::ADDR_BITS-1:smmd_pkg::SLOT_BITS];
        plan.base = smmd_pkg::ADDR_BITS'(item.address - item.source_address);
        if (len_bad) begin
          plan.status = smmd_pkg::ST_LEN;
        end else if (src_misal || dst_misal) begin
          plan.status = smmd_pkg::ST_BAD_ARG;
        end else if (!src_rng_ok || !dst_rng_ok) begin
          plan.status = smmd_pkg::ST_RANGE;
        end
      end
      smmd_pkg::OP_RD_LOOKUP, smmd_pkg::OP_WR_LOOKUP: begin
        plan.status = smmd_pkg::ST_OK;
      end
      default: begin
        plan.status = smmd_pkg::ST_MODE;
      end
    endcase
  end

endmodule

### hdl/smmd_map_store.sv
// Mapping store: read-map and write-map RAMs sharing one command from the sequencer.
// Depends on smmd_pkg and smmd_ram; the sequencer clears both RAMs after reset.
module smmd_map_store (
  input  logic                 clk,
  input  smmd_pkg::store_cmd_t cmd,
  output smmd_pkg::entry_t     rd_q,
  output smmd_pkg::entry_t     wr_q
);

  // Read mapping memory.
  smmd_ram #(.WIDTH($bits(smmd_pkg::entry_t)), .DEPTH(smmd_pkg::SLOT_COUNT)) u_rd_ram (
    .clk   (clk),
    .we    (cmd.rd_we),
    .waddr (cmd.waddr),
    .wdata (cmd.rd_wdata),
    .raddr (cmd.raddr),
    .rdata (rd_q)
  );

  // Write mapping memory.
  smmd_ram #(.WIDTH($bits(smmd_pkg::entry_t)), .DEPTH(smmd_pkg::SLOT_COUNT)) u_wr_ram (
    .clk   (clk),
    .we    (cmd.wr_we),
    .waddr (cmd.waddr),
    .wdata (cmd.wr_wdata),
    .raddr (cmd.raddr),
    .rdata (wr_q)
  );

endmodule

### hdl/slot_memory_map_decoder.sv
// Slot memory map decoder top level: sequencer over the check unit and mapping store.
// Depends on smmd_pkg, smmd_in_if, smmd_out_if, smmd_check, smmd_map_store and the
// assertion macros header.
//
// Usage: items enter on in_ch (valid/ready) and each gives exactly one result on
// out_ch (valid/ready). in_ch.ready is high only while the sequencer is idle.
// Sequencer steps, from the accepted item to the result in the output register:
//   lookups:                                   check (table read issued), look, finish
//   failed checks, zero-length runs:           check, finish
//   allocate of n slots:                       check, one RAM write per slot, finish
//   restore or map window of n slots:          check, a read then a write per slot, finish
//   free:                                      check, a read then a write per slot, finish (walks every slot)
// The next item is taken on the cycle after the result is loaded, so the block
// takes no new item before it is through with the last one. The write port and
// registered read port of each mapping RAM set the per-slot cost.
// After reset the sequencer writes the unmapped value into every slot of both RAMs,
// one slot per cycle; in_ch.ready rises once the last slot is cleared.
// If the receiver stalls, the result waits in the output register while the block
// takes and processes the next item; that item's result waits in the sequencer
// until the output register frees up.
`include "slot_memory_map_decoder_macros.svh"

module slot_memory_map_decoder (
  input  logic              clk,
  input  logic              rst_n,
  smmd_in_if.sink           in_ch,
  smmd_out_if.source        out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_CHECK,
    S_ALLOC,
    S_STEP_RD,
    S_STEP_WR,
    S_LOOK,
    S_FINISH
  } state_t;

  state_t                             state_r, state_nxt;
  smmd_pkg::item_t                    item_r, item_nxt;
  logic [smmd_pkg::CNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [smmd_pkg::SLOT_IDX_BITS-1:0] dst_r, dst_nxt;
  logic [smmd_pkg::SLOT_IDX_BITS-1:0] src_r, src_nxt;
  logic [smmd_pkg::ADDR_BITS-1:0]     base_r, base_nxt;
  smmd_pkg::result_t                  res_r, res_nxt;
  smmd_pkg::result_t                  out_res_r, out_res_nxt;
  logic                               out_valid_r, out_valid_nxt;

  smmd_pkg::plan_t      plan;
  smmd_pkg::store_cmd_t cmd;
  smmd_pkg::entry_t     rd_q;
  smmd_pkg::entry_t     wr_q;
  smmd_pkg::entry_t     look_e;
  logic                 last_slot;
  logic                 run_ok;
  logic                 miss_ok;

  // Argument checks on the held item.
  smmd_check u_check (
    .item (item_r),
    .plan (plan)
  );

  // Read and write mapping tables.
  smmd_map_store u_store (
    .clk   (clk),
    .cmd   (cmd),
    .rd_q  (rd_q),
    .wr_q  (wr_q)
  );

  assign last_slot = (cnt_r == smmd_pkg::CNT_BITS'(1));
  assign look_e    = (item_r.operation == smmd_pkg::OP_RD_LOOKUP) ? rd_q : wr_q;

  // Sequencer next-state and store command.
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    dst_nxt       = dst_r;
    src_nxt       = src_r;
    base_nxt      = base_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.raddr     = src_r;
    cmd.waddr     = dst_r;

    // The receiver took the waiting result.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt.operation      = in_ch.operation;
          item_nxt.block_id       = in_ch.block_id;
          item_nxt.block_size     = in_ch.block_size;
          item_nxt.use_block_size = in_ch.use_block_size;
          item_nxt.source_offset  = in_ch.source_offset;
          item_nxt.address        = in_ch.address;
          item_nxt.source_address = in_ch.source_address;
          item_nxt.length         = in_ch.length;
          item_nxt.access_mode    = in_ch.access_mode;
          state_nxt               = S_CHECK;
        end
      end
      S_CLEAR: begin
        // Write the unmapped value into one slot of both tables per cycle.
        cmd.rd_we = 1'b1;
        cmd.wr_we = 1'b1;
        dst_nxt   = dst_r + smmd_pkg::SLOT_IDX_BITS'(1);
        if (dst_r == smmd_pkg::SLOT_IDX_BITS'(smmd_pkg::SLOT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_CHECK: begin
        // Load the slot run; lookups start their table read here.
        cnt_nxt   = plan.n_slots;
        dst_nxt   = plan.dst_first;
        src_nxt   = plan.src_first;
        base_nxt  = plan.base;
        cmd.raddr = plan.dst_first;
        res_nxt   = '{status: plan.status, hit: 1'b0, found_block: '0, block_offset: '0};
        if (plan.status != smmd_pkg::ST_OK) begin
          state_nxt = S_FINISH;
        end else if ((item_r.operation == smmd_pkg::OP_RD_LOOKUP) ||
                     (item_r.operation == smmd_pkg::OP_WR_LOOKUP)) begin
          state_nxt = S_LOOK;
        end else if (plan.n_slots == '0) begin
          state_nxt = S_FINISH;
        end else if (item_r.operation == smmd_pkg::OP_ALLOC) begin
          state_nxt = S_ALLOC;
        end else begin
          state_nxt = S_STEP_RD;
        end
      end
      S_ALLOC: begin
        // One slot per cycle into the selected table or tables.
        cmd.rd_wdata = '{id: item_r.block_id, base: base_r};
        cmd.wr_wdata = '{id: item_r.block_id, base: base_r};
        cmd.rd_we    = (item_r.access_mode != smmd_pkg::MODE_WR);
        cmd.wr_we    = (item_r.access_mode != smmd_pkg::MODE_RD);
        cnt_nxt      = cnt_r - smmd_pkg::CNT_BITS'(1);
        dst_nxt      = dst_r + smmd_pkg::SLOT_IDX_BITS'(1);
        if (last_slot) begin
          state_nxt = S_FINISH;
        end
      end
      S_STEP_RD: begin
        cmd.raddr = src_r;
        state_nxt = S_STEP_WR;
      end
      S_STEP_WR: begin
        // Read data of the source slot is here; write the destination slot.
        case (item_r.operation)
          smmd_pkg::OP_RESTORE: begin
            if (item_r.access_mode == smmd_pkg::MODE_RD) begin
              cmd.rd_we    = 1'b1;
              cmd.rd_wdata = wr_q;
            end else begin
              cmd.wr_we    = 1'b1;
              cmd.wr_wdata = rd_q;
            end
          end
          smmd_pkg::OP_FREE: begin
            // A matching mapping is overwritten with the unmapped value.
            cmd.rd_we = (rd_q.id == item_r.block_id);
            cmd.wr_we = (wr_q.id == item_r.block_id);
          end
          smmd_pkg::OP_WINDOW: begin
            cmd.rd_we    = 1'b1;
            cmd.wr_we    = 1'b1;
            cmd.rd_wdata = '{id: rd_q.id, base: rd_q.base + base_r};
            cmd.wr_wdata = '{id: wr_q.id, base: wr_q.base + base_r};
          end
          default: begin
            cmd.rd_we = 1'b0;
          end
        endcase
        cnt_nxt = cnt_r - smmd_pkg::CNT_BITS'(1);
        dst_nxt = dst_r + smmd_pkg::SLOT_IDX_BITS'(1);
        src_nxt = src_r + smmd_pkg::SLOT_IDX_BITS'(1);
        state_nxt = last_slot ? S_FINISH : S_STEP_RD;
      end
      S_LOOK: begin
        // A mapped slot gives the block and the offset from its base.
        if (look_e.id != '0) begin
          res_nxt.hit          = 1'b1;
          res_nxt.found_block  = look_e.id;
          res_nxt.block_offset =
            item_r.address[smmd_pkg::ADDR_BITS-1:0] - look_e.base;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs; reset starts the clearing pass at slot 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      dst_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dst_r       <= dst_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r    <= item_nxt;
    cnt_r     <= cnt_nxt;
    src_r     <= src_nxt;
    base_r    <= base_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.hit          = out_res_r.hit;
  assign out_ch.found_block  = out_res_r.found_block;
  assign out_ch.block_offset = out_res_r.block_offset;

  // Terms for the checks below.
  assign run_ok  = (({1'b0, dst_r} + cnt_r) <= smmd_pkg::CNT_BITS'(smmd_pkg::SLOT_COUNT));
  assign miss_ok = (out_ch.found_block == '0) && (out_ch.block_offset == '0);

  // Checks on the sequencer.
  `SMMD_ASSERT_NXT(a_accept_check, in_ch.valid && in_ch.ready, state_r == S_CHECK, "no check")
  `SMMD_ASSERT_IMP(a_loop_cnt, state_r == S_ALLOC || state_r == S_STEP_WR, cnt_r != '0, "cnt")
  `SMMD_ASSERT_IMP(a_run_fits, state_r == S_ALLOC || state_r == S_STEP_RD, run_ok, "run overflow")
  `SMMD_ASSERT_IMP(a_miss_zero, out_ch.valid && !out_ch.hit, miss_ok, "miss fields")
  `SMMD_ASSERT_IMP(a_rise_finish, $rose(out_ch.valid), $past(state_r == S_FINISH), "rise")

endmodule
